FILE: rtl/ansi_escape_line_filter_core_defines.svh
// Assertion macros used by the checker file.
`ifndef ANSI_ESCAPE_LINE_FILTER_CORE_DEFINES_SVH
`define ANSI_ESCAPE_LINE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define AELF_CHECK_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("aelf check failed");

// Next-cycle implication, disabled in reset.
`define AELF_CHECK_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("aelf check failed");

`endif

FILE: rtl/aelf_pkg.sv
`default_nettype none

package aelf_pkg;

  // escape tracking
  typedef enum logic [1:0] {
    PH_NORMAL    = 2'd0,
    PH_AFTER_ESC = 2'd1,
    PH_IN_SEQ    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       le;
    logic       fin;
  } result_t;

  // one queued item: one or two result beats
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } record_t;

  typedef struct packed {
    phase_t     phase;
    logic       nul;
    logic       emit;
    logic [7:0] ch;
  } text_t;

  localparam logic [7:0] C_NUL      = 8'h00;
  localparam logic [7:0] C_NL       = 8'h0A;
  localparam logic [7:0] C_ESC      = 8'h1B;
  localparam logic [7:0] C_SPACE    = 8'h20;
  localparam logic [7:0] C_DOT      = 8'h2E;
  localparam logic [7:0] C_FINAL_LO = 8'h40;
  localparam logic [7:0] C_CAP_O    = 8'h4F;
  localparam logic [7:0] C_LBRACK   = 8'h5B;
  localparam logic [7:0] C_FINAL_HI = 8'h7E;
  localparam logic [7:0] C_DEL      = 8'h7F;
  localparam logic [7:0] C_UP_A     = 8'h41;
  localparam logic [7:0] C_UP_Z     = 8'h5A;
  localparam logic [7:0] C_LO_A     = 8'h61;
  localparam logic [7:0] C_LO_Z     = 8'h7A;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // config space
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_ONLY = '0;

  // one non-newline byte through the escape filter
  function automatic text_t text_step(phase_t ph, logic [7:0] c, logic letters);
    text_t t;
    logic  kept;
    kept    = 1'b0;
    t.phase = ph;
    t.nul   = 1'b0;
    t.emit  = 1'b0;
    t.ch    = c;
    priority if (c == C_NUL) begin
      t.nul   = 1'b1;
      t.phase = PH_NORMAL;
    end else if (ph == PH_IN_SEQ) begin
      if (c >= C_FINAL_LO && c <= C_FINAL_HI) t.phase = PH_NORMAL;
    end else if (ph == PH_AFTER_ESC && (c == C_LBRACK || c == C_CAP_O)) begin
      t.phase = PH_IN_SEQ;
    end else begin
      t.phase = PH_NORMAL;
      if (c == C_ESC) begin
        t.phase = PH_AFTER_ESC;
      end else if (c >= C_SPACE && c < C_DEL) begin
        if (letters) begin
          kept = (c >= C_UP_A && c <= C_UP_Z) || (c >= C_LO_A && c <= C_LO_Z) ||
                 (c == C_SPACE);
        end else begin
          kept = 1'b1;
        end
        t.emit = kept;
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ansi_escape_line_filter_core.sv
// Line filter for a terminal byte stream: strips ANSI escapes and control bytes.
// Input channel (in_valid/in_stall): one raw byte per beat, or an end_of_stream
//   marker. Bytes are taken one per cycle while the internal queue has room.
// Output channel (out_valid/out_stall): one kept character, a line_end marker
//   or the finished marker per beat; last flags the final beat of each input.
// Path: a result is written into the queue, then loaded into the output register.
// Throughput: one input per cycle while the queue has room; an input giving two
//   results (released dot plus a character, or line end plus finished) takes
//   two output beats, and the queue absorbs that until it fills.
// Receiver stall holds the output register; the queue then fills and in_stall
//   rises once QUEUE_DEPTH records wait. in_stall follows the queue alone, so
//   while it is full every input waits, even one that would give no result.
// After finished, later inputs are taken and dropped.
// Reset (rst, synchronous) clears the queue, the line state and alpha_only.
// Config: APB register 0 at address 0, bit 0 = alpha_only; write while idle.
`default_nettype none

module ansi_escape_line_filter_core #(
  parameter int QUEUE_DEPTH = aelf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // config
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [aelf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // input beats
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_byte,
  input  wire logic                        end_of_stream,
  // output beats
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_char,
  output logic                             line_end,
  output logic                             finished,
  output logic                             last
);

  logic                            alpha_only;
  logic [aelf_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                            q_push, q_pop, q_full, q_nonempty;
  aelf_pkg::record_t               push_rec, q_head;

  // register file: a single bit
  assign pready  = 1'b1;
  assign reg_idx = paddr[aelf_pkg::ADDR_W-1:2];

  always_comb begin
    prdata = '0;
    if (reg_idx == aelf_pkg::REG_ALPHA_ONLY) prdata[0] = alpha_only;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_only <= 1'b0;
    end else if (psel && penable && pwrite && reg_idx == aelf_pkg::REG_ALPHA_ONLY) begin
      alpha_only <= pwdata[0];
    end
  end

  // front: line/escape state, builds one record per input that gives results
  aelf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .alpha_only    (alpha_only),
    .q_full        (q_full),
    .push          (q_push),
    .push_rec      (push_rec)
  );

  // short queue decouples the front from the output stall
  aelf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // back: splits records into beats, holds the output register
  aelf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .line_end   (line_end),
    .finished   (finished),
    .last       (last)
  );

endmodule

`default_nettype wire

FILE: rtl/aelf_front.sv
`default_nettype none

module aelf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_stream,
  input  wire logic              alpha_only,
  input  wire logic              q_full,
  output logic                   push,
  output aelf_pkg::record_t      push_rec
);

  aelf_pkg::phase_t phase, phase_next;
  logic at_line_start, at_line_start_next;
  logic dot_held, dot_held_next;
  logic line_nonempty, line_nonempty_next;
  logic discard_rest, discard_rest_next;
  logic stopped, stopped_next;

  logic acc;
  logic is_nl, is_dot, is_nul;
  aelf_pkg::text_t t_dot, t_c;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full && !stopped;

  // classify
  always_comb begin
    is_nl  = (in_byte == aelf_pkg::C_NL);
    is_dot = (in_byte == aelf_pkg::C_DOT);
    is_nul = (in_byte == aelf_pkg::C_NUL);
    t_dot  = aelf_pkg::text_step(phase, aelf_pkg::C_DOT, alpha_only);
    t_c    = aelf_pkg::text_step(dot_held ? t_dot.phase : phase, in_byte, alpha_only);
  end

  // next state
  always_comb begin
    phase_next         = phase;
    at_line_start_next = at_line_start;
    dot_held_next      = dot_held;
    line_nonempty_next = line_nonempty;
    discard_rest_next  = discard_rest;
    stopped_next       = stopped;
    if (acc) begin
      priority if (end_of_stream) begin
        stopped_next = 1'b1;
      end else if (is_nl) begin
        if (dot_held) stopped_next = 1'b1;
        phase_next         = aelf_pkg::PH_NORMAL;
        at_line_start_next = 1'b1;
        dot_held_next      = 1'b0;
        line_nonempty_next = 1'b0;
        discard_rest_next  = 1'b0;
      end else if (discard_rest) begin
        at_line_start_next = 1'b0;
      end else if (at_line_start && is_dot) begin
        at_line_start_next = 1'b0;
        dot_held_next      = 1'b1;
      end else begin
        at_line_start_next = 1'b0;
        dot_held_next      = 1'b0;
        if (dot_held && is_nul) begin
          stopped_next = 1'b1;
        end else begin
          phase_next         = t_c.phase;
          discard_rest_next  = t_c.nul;
          line_nonempty_next = line_nonempty | t_c.emit | (dot_held & t_dot.emit);
        end
      end
    end
  end

  // record to queue
  always_comb begin
    aelf_pkg::result_t rc0, rc1;
    logic has;
    logic e0;
    rc0      = '{ch: 8'h00, le: 1'b0, fin: 1'b0};
    rc1      = rc0;
    has      = 1'b0;
    e0       = dot_held & t_dot.emit;
    push_rec = '0;
    priority if (end_of_stream) begin
      has = 1'b1;
      if (!dot_held && line_nonempty) begin
        rc0.le        = 1'b1;
        rc1.fin       = 1'b1;
        push_rec.two  = 1'b1;
      end else begin
        rc0.fin = 1'b1;
      end
    end else if (is_nl) begin
      if (dot_held) begin
        rc0.fin = 1'b1;
        has     = 1'b1;
      end else if (line_nonempty) begin
        rc0.le = 1'b1;
        has    = 1'b1;
      end
    end else if (discard_rest || (at_line_start && is_dot)) begin
      has = 1'b0;
    end else if (dot_held && is_nul) begin
      rc0.fin = 1'b1;
      has     = 1'b1;
    end else begin
      if (e0 && t_c.emit) begin
        rc0.ch       = aelf_pkg::C_DOT;
        rc1.ch       = t_c.ch;
        push_rec.two = 1'b1;
        has          = 1'b1;
      end else if (e0) begin
        rc0.ch = aelf_pkg::C_DOT;
        has    = 1'b1;
      end else if (t_c.emit) begin
        rc0.ch = t_c.ch;
        has    = 1'b1;
      end
    end
    push_rec.r0 = rc0;
    push_rec.r1 = rc1;
    push        = acc && has;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= aelf_pkg::PH_NORMAL;
      at_line_start <= 1'b1;
      dot_held      <= 1'b0;
      line_nonempty <= 1'b0;
      discard_rest  <= 1'b0;
      stopped       <= 1'b0;
    end else begin
      phase         <= phase_next;
      at_line_start <= at_line_start_next;
      dot_held      <= dot_held_next;
      line_nonempty <= line_nonempty_next;
      discard_rest  <= discard_rest_next;
      stopped       <= stopped_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/aelf_queue.sv
`default_nettype none

module aelf_queue #(
  parameter int DEPTH = aelf_pkg::QUEUE_DEPTH_DEFAULT  // 2 or more
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire aelf_pkg::record_t push_rec,
  input  wire logic              pop,
  output logic                   full,
  output logic                   nonempty,
  output aelf_pkg::record_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  aelf_pkg::record_t  slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_rec;
  end

endmodule

`default_nettype wire

FILE: rtl/aelf_back.sv
`default_nettype none

module aelf_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_nonempty,
  input  wire aelf_pkg::record_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_char,
  output logic                   line_end,
  output logic                   finished,
  output logic                   last
);

  logic              out_valid_next;
  logic              sec_valid, sec_valid_next;
  aelf_pkg::result_t sec, sec_next;
  aelf_pkg::result_t cur, cur_next;
  logic              last_next;
  logic              load;

  assign load  = !out_valid || !out_stall;
  assign q_pop = load && !sec_valid && q_nonempty;

  assign out_char = cur.ch;
  assign line_end = cur.le;
  assign finished = cur.fin;

  always_comb begin
    out_valid_next = out_valid;
    sec_valid_next = sec_valid;
    sec_next       = sec;
    cur_next       = cur;
    last_next      = last;
    if (load) begin
      priority if (sec_valid) begin
        cur_next       = sec;
        last_next      = 1'b1;
        out_valid_next = 1'b1;
        sec_valid_next = 1'b0;
      end else if (q_nonempty) begin
        cur_next       = q_head.r0;
        last_next      = !q_head.two;
        out_valid_next = 1'b1;
        sec_valid_next = q_head.two;
        sec_next       = q_head.r1;
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      sec_valid <= sec_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sec  <= sec_next;
    cur  <= cur_next;
    last <= last_next;
  end

endmodule

`default_nettype wire

FILE: rtl/aelf_checker.sv
`default_nettype none
`include "ansi_escape_line_filter_core_defines.svh"

module aelf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       line_end,
  input wire logic       finished,
  input wire logic       last
);

  `AELF_CHECK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_char) && $stable(line_end) && $stable(finished) && $stable(last))
  `AELF_CHECK_NOW(a_marker_no_char, clk, rst, out_valid && (line_end || finished), out_char == 8'h00)
  `AELF_CHECK_NOW(a_marker_excl, clk, rst, out_valid, !(line_end && finished))
  `AELF_CHECK_NOW(a_fin_last, clk, rst, out_valid && finished, last)
  `AELF_CHECK_NEXT(a_fin_final, clk, rst, out_valid && !out_stall && finished, !out_valid)

endmodule

bind ansi_escape_line_filter_core aelf_checker u_aelf_checker (.*);

`default_nettype wire

FILE: test/ansi_escape_line_filter_core_tb.sv
`timescale 1ns / 1ps

module ansi_escape_line_filter_core_tb;

  // One output beat as the checker sees it.
  typedef struct packed {
    logic [7:0] ch;
    logic       le;
    logic       fin;
    logic       last;
  } beat_t;

  // How a side spaces its beats: spread over 0..17, mostly back to back, or never idle.
  typedef enum int {
    IDLE_SPREAD,
    IDLE_SPARSE,
    IDLE_NONE
  } idle_mode_t;

  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned PHASE_ITEMS = 258;
  localparam int unsigned LONG_HOLD   = 90;
  localparam int unsigned SETTLE      = 6;

  // How the run is closed: each one stops the stream in its own way.
  typedef enum int {
    STOP_EOS_TEXT,
    STOP_EOS_EMPTY,
    STOP_EOS_DOT,
    STOP_DOT_NL,
    STOP_DOT_NUL
  } stop_kind_t;

  // ---------------------------------------------------------------------------
  // Cleaned-text scoreboard: tracks the line and escape state of the filter,
  // turns every accepted input beat into the output beats it should give, and
  // checks output beats against them in order.
  // ---------------------------------------------------------------------------
  class clean_text_board;
    bit                letters_mode;
    aelf_pkg::phase_t  esc_ph;
    bit                line_fresh;
    bit                dot_pending;
    bit                line_has_text;
    bit                skip_line;
    bit                halted;
    beat_t             clean_beats[$];
    beat_t             step_beats[$];
    int unsigned       faults;

    function new();
      letters_mode  = 1'b0;
      esc_ph        = aelf_pkg::PH_NORMAL;
      line_fresh    = 1'b1;
      dot_pending   = 1'b0;
      line_has_text = 1'b0;
      skip_line     = 1'b0;
      halted        = 1'b0;
      faults        = 0;
    endfunction

    function void add_beat(logic [7:0] ch, logic le, logic fin);
      beat_t b;
      b.ch   = ch;
      b.le   = le;
      b.fin  = fin;
      b.last = 1'b0;
      step_beats.push_back(b);
    endfunction

    // one non-newline byte through the escape stripper and the char filter
    function void strip_byte(logic [7:0] c);
      bit keep;
      if (c == aelf_pkg::C_NUL) begin
        skip_line = 1'b1;
        esc_ph    = aelf_pkg::PH_NORMAL;
      end else if (esc_ph == aelf_pkg::PH_IN_SEQ) begin
        if (c >= aelf_pkg::C_FINAL_LO && c <= aelf_pkg::C_FINAL_HI)
          esc_ph = aelf_pkg::PH_NORMAL;
      end else if (esc_ph == aelf_pkg::PH_AFTER_ESC &&
                   (c == aelf_pkg::C_LBRACK || c == aelf_pkg::C_CAP_O)) begin
        esc_ph = aelf_pkg::PH_IN_SEQ;
      end else if (c == aelf_pkg::C_ESC) begin
        esc_ph = aelf_pkg::PH_AFTER_ESC;
      end else begin
        esc_ph = aelf_pkg::PH_NORMAL;
        if (letters_mode)
          keep = (c >= aelf_pkg::C_UP_A && c <= aelf_pkg::C_UP_Z) ||
                 (c >= aelf_pkg::C_LO_A && c <= aelf_pkg::C_LO_Z) ||
                 c == aelf_pkg::C_SPACE;
        else
          keep = c >= aelf_pkg::C_SPACE && c < aelf_pkg::C_DEL;
        if (keep) begin
          line_has_text = 1'b1;
          add_beat(c, 1'b0, 1'b0);
        end
      end
    endfunction

    // accepted input beat
    function void take_byte(logic [7:0] c, logic eos);
      step_beats.delete();
      if (halted) begin
        // stream over: everything is swallowed
      end else if (eos) begin
        if (!dot_pending && line_has_text) add_beat(8'h00, 1'b1, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1);
        halted = 1'b1;
      end else if (c == aelf_pkg::C_NL) begin
        if (dot_pending) begin
          add_beat(8'h00, 1'b0, 1'b1);
          halted = 1'b1;
        end else if (line_has_text) begin
          add_beat(8'h00, 1'b1, 1'b0);
        end
        esc_ph        = aelf_pkg::PH_NORMAL;
        line_fresh    = 1'b1;
        dot_pending   = 1'b0;
        line_has_text = 1'b0;
        skip_line     = 1'b0;
      end else if (skip_line) begin
        line_fresh = 1'b0;
      end else if (line_fresh && c == aelf_pkg::C_DOT) begin
        line_fresh  = 1'b0;
        dot_pending = 1'b1;
      end else begin
        line_fresh = 1'b0;
        if (dot_pending) begin
          dot_pending = 1'b0;
          if (c == aelf_pkg::C_NUL) begin
            // dot then NUL counts as a dot line
            add_beat(8'h00, 1'b0, 1'b1);
            halted = 1'b1;
          end else begin
            strip_byte(aelf_pkg::C_DOT);
            strip_byte(c);
          end
        end else begin
          strip_byte(c);
        end
      end
      if (step_beats.size() != 0) step_beats[step_beats.size()-1].last = 1'b1;
      foreach (step_beats[i]) clean_beats.push_back(step_beats[i]);
    endfunction

    // accepted output beat
    function void match_beat(beat_t got);
      beat_t want;
      if (clean_beats.size() == 0) begin
        faults++;
        $display("%0t: beat with nothing expected: ch=%h le=%b fin=%b last=%b",
                 $time, got.ch, got.le, got.fin, got.last);
      end else begin
        want = clean_beats.pop_front();
        if (got !== want) begin
          faults++;
          if (got.ch !== want.ch)
            $display("%0t: out_char expected %h actual %h", $time, want.ch, got.ch);
          if (got.le !== want.le)
            $display("%0t: line_end expected %b actual %b", $time, want.le, got.le);
          if (got.fin !== want.fin)
            $display("%0t: finished expected %b actual %b", $time, want.fin, got.fin);
          if (got.last !== want.last)
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Block hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [aelf_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_byte = 8'h00;
  logic                          end_of_stream = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_char;
  logic                          line_end;
  logic                          finished;
  logic                          last;

  ansi_escape_line_filter_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .line_end      (line_end),
    .finished      (finished),
    .last          (last)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  clean_text_board sb;
  idle_mode_t      send_mode = IDLE_SPREAD;
  idle_mode_t      recv_mode = IDLE_SPREAD;
  bit              long_hold = 1'b0;  // asks the sink for one long stall
  logic [7:0]      line_q[$];         // bytes of the line being sent

  function automatic int unsigned draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_SPREAD: return $urandom_range(0, 17);
      IDLE_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
      default:     return 0;
    endcase
  endfunction

  // Offer one input beat after a drawn gap and hold it until it is taken.
  // The scoreboard sees the beat at the edge that accepts it.
  task automatic send_beat(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = draw_wait(send_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b, eos);
  endtask

  // Sender pause: nothing offered until every expected beat is out, then a
  // SETTLE wait for beats that gave no result and are still in the pipe.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.clean_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write of alpha_only, then read it back. Upper data bits are junk
  // on purpose; only bit 0 means anything.
  task automatic write_letters(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {aelf_pkg::REG_ALPHA_ONLY, 2'b00};
    pwdata  <= {31'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.letters_mode = v;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== v) begin
      sb.faults++;
      $display("%0t: alpha_only read expected %b actual %b", $time, v, prdata[0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random line: mostly printable text with CSI / SS3 / lone ESC pieces,
  // control and high bytes mixed in, sometimes a leading dot or a NUL.
  // One line in ten is plain noise, newlines included.
  function automatic void build_line();
    int unsigned len;
    int unsigned r;
    int unsigned n;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 7) == 0) line_q.push_back(aelf_pkg::C_DOT);
    len = $urandom_range(0, 16);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        line_q.push_back(8'($urandom_range(32, 126)));
      end else if (r < 65) begin
        n = $urandom_range(0, 52);
        if (n == 52)      line_q.push_back(aelf_pkg::C_SPACE);
        else if (n < 26)  line_q.push_back(aelf_pkg::C_UP_A + 8'(n));
        else              line_q.push_back(aelf_pkg::C_LO_A + 8'(n - 26));
      end else if (r < 73) begin
        // CSI: params / intermediates, then a final byte
        line_q.push_back(aelf_pkg::C_ESC);
        line_q.push_back(aelf_pkg::C_LBRACK);
        n = $urandom_range(0, 3);
        repeat (n) line_q.push_back(8'($urandom_range(32, 63)));
        line_q.push_back(8'($urandom_range(64, 126)));
      end else if (r < 77) begin
        line_q.push_back(aelf_pkg::C_ESC);
        line_q.push_back(aelf_pkg::C_CAP_O);
        line_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 81) begin
        line_q.push_back(aelf_pkg::C_ESC);
        line_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 88) begin
        n = $urandom_range(1, 31);
        if (n == 10) n = 13;
        line_q.push_back(8'(n));
      end else if (r < 93) begin
        line_q.push_back(8'($urandom_range(127, 255)));
      end else if (r < 95) begin
        line_q.push_back(aelf_pkg::C_NUL);
      end else begin
        line_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    line_q.push_back(aelf_pkg::C_NL);
  endfunction

  // ---------------------------------------------------------------------------
  // Output sink: draws a stall per beat, or one long hold when asked, and
  // hands every accepted beat to the scoreboard.
  // ---------------------------------------------------------------------------
  initial begin : sink
    beat_t       got;
    int unsigned hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        hold      = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = draw_wait(recv_mode);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.ch   = out_char;
      got.le   = line_end;
      got.fin  = finished;
      got.last = last;
      sb.match_beat(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim
    int unsigned sent;
    logic [7:0]  b;
    logic        start_mode;
    stop_kind_t  stop_kind;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opener, alpha_only at its reset value: printable edges, DEL,
    // high bytes, CR, a CSI, an SS3, a lone ESC, a released dot, a NUL line,
    // and a newline cutting an escape short.
    line_q = '{aelf_pkg::C_UP_A, aelf_pkg::C_SPACE, aelf_pkg::C_FINAL_HI,
               aelf_pkg::C_DEL, 8'h80, 8'hFF, 8'h0D,
               aelf_pkg::C_ESC, aelf_pkg::C_LBRACK, 8'h31, 8'h6D,
               aelf_pkg::C_ESC, aelf_pkg::C_CAP_O, 8'h50,
               aelf_pkg::C_ESC, 8'h78, aelf_pkg::C_NL,
               aelf_pkg::C_DOT, aelf_pkg::C_LO_A,
               aelf_pkg::C_NUL, aelf_pkg::C_LO_Z, aelf_pkg::C_NL,
               aelf_pkg::C_ESC, aelf_pkg::C_LBRACK, aelf_pkg::C_NL};
    while (line_q.size() != 0) send_beat(line_q.pop_front(), 1'b0);

    // Random phases; alpha_only flips every phase, both sides change pacing.
    start_mode = 1'($urandom_range(0, 1));
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_block();
      write_letters(start_mode ^ ph[0]);
      send_mode = idle_mode_t'(ph % 3);
      recv_mode = idle_mode_t'((ph + 1) % 3);
      if (ph == 2) begin
        // sink holds off while letters stream in back to back: fills the queue
        long_hold = 1'b1;
        repeat (32) send_beat(aelf_pkg::C_UP_A + 8'($urandom_range(0, 25)), 1'b0);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_line();
        while (line_q.size() != 0 && sent < PHASE_ITEMS) begin
          b = line_q.pop_front();
          // keep the stream alive: no dot line before the very end
          if (sb.dot_pending && (b == aelf_pkg::C_NL || b == aelf_pkg::C_NUL))
            b = aelf_pkg::C_LO_A;
          send_beat(b, 1'b0);
          sent++;
          if (ph == 3 && sent == PHASE_ITEMS / 2) drain_block();
        end
      end
    end

    // Close the stream one of several ways, on a fresh line.
    drain_block();
    send_mode = IDLE_SPARSE;
    send_beat(aelf_pkg::C_LO_A + 8'd10, 1'b0);
    send_beat(aelf_pkg::C_NL, 1'b0);
    stop_kind = stop_kind_t'($urandom_range(0, 4));
    case (stop_kind)
      STOP_EOS_TEXT: begin
        send_beat(aelf_pkg::C_LO_A, 1'b0);
        send_beat(aelf_pkg::C_UP_Z, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      STOP_EOS_EMPTY: send_beat(8'($urandom_range(0, 255)), 1'b1);
      STOP_EOS_DOT: begin
        send_beat(aelf_pkg::C_DOT, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      STOP_DOT_NL: begin
        send_beat(aelf_pkg::C_DOT, 1'b0);
        send_beat(aelf_pkg::C_NL, 1'b0);
      end
      default: begin
        send_beat(aelf_pkg::C_DOT, 1'b0);
        send_beat(aelf_pkg::C_NUL, 1'b0);
      end
    endcase
    // after the stop every beat, end_of_stream too, must vanish
    repeat (6) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    drain_block();
    repeat (SETTLE) @(posedge clk);
    if (sb.faults == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #6000000;
    $display("tb: failure");
    $finish;
  end

endmodule
